// ===== src/gdt_pkg.sv =====
// ----------------------------------------------------------------------------
// gdt_pkg: graph traversal shared types
// Word formats, opcodes, register indexes, FSM states and datapath commands.
// ----------------------------------------------------------------------------
package gdt_pkg;

    localparam int VERTEX_W = 6;
    localparam int CFG_W    = 7;

    localparam logic [1:0] OP_ADD_EDGE = 2'd0;
    localparam logic [1:0] OP_RUN_DFS  = 2'd1;
    localparam logic [1:0] OP_RUN_BFS  = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    localparam logic CFG_VERTEX_COUNT   = 1'b0;
    localparam logic CFG_DELETED_VERTEX = 1'b1;

    localparam logic [CFG_W-1:0] VERTEX_COUNT_RST = 7'd64;
    localparam logic [CFG_W-1:0] DELETED_NONE     = 7'd64;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
    } in_word_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic                empty_res;
        logic                last;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE_A,
        ST_EDGE_B,
        ST_DFS_SEEK,
        ST_DFS_EXPAND,
        ST_DFS_POP,
        ST_BFS_SEEK,
        ST_BFS_EXPAND,
        ST_BFS_ENQ,
        ST_BFS_DEQ
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_EDGE_A,
        CMD_EDGE_B,
        CMD_DFS_START,
        CMD_DFS_PUSH,
        CMD_DFS_POP,
        CMD_DFS_RESUME,
        CMD_BFS_START,
        CMD_BFS_EXPAND,
        CMD_BFS_ENQ,
        CMD_BFS_DEQ_REQ,
        CMD_BFS_DEQ,
        CMD_FINISH
    } cmd_t;

    typedef struct packed {
        logic edge_ok;      // both endpoints below the effective count
        logic left_zero;    // no unvisited active vertex remains
        logic nb_zero;      // fetched row has no unvisited active neighbor
        logic pend_zero;    // BFS neighbor set fully enqueued
        logic top_one;      // DFS stack holds a single entry
        logic queue_empty;  // BFS queue head caught up with tail
    } status_t;

endpackage

// ===== src/gdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdt_ctrl: traversal sequencer
// Walks edge updates and DFS/BFS runs, issuing at most one datapath command a cycle.
// ----------------------------------------------------------------------------
module gdt_ctrl
    import gdt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic [1:0] opcode,
    input  status_t  status,
    output logic     busy,
    output cmd_t     cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd = CMD_ACCEPT;
                    case (opcode)
                        OP_ADD_EDGE: state_next = status.edge_ok ? ST_EDGE_A : ST_IDLE;
                        OP_RUN_DFS:  state_next = ST_DFS_SEEK;
                        OP_RUN_BFS:  state_next = ST_BFS_SEEK;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EDGE_A:
            begin
                cmd        = CMD_EDGE_A;
                state_next = ST_EDGE_B;
            end
            ST_EDGE_B:
            begin
                cmd        = CMD_EDGE_B;
                state_next = ST_IDLE;
            end
            ST_DFS_SEEK:
            begin
                if (status.left_zero)
                begin
                    cmd        = CMD_FINISH;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd        = CMD_DFS_START;
                    state_next = ST_DFS_EXPAND;
                end
            end
            ST_DFS_EXPAND:
            begin
                if (!status.nb_zero)
                begin
                    cmd        = CMD_DFS_PUSH;
                    state_next = ST_DFS_EXPAND;
                end
                else
                begin
                    cmd        = CMD_DFS_POP;
                    state_next = status.top_one ? ST_DFS_SEEK : ST_DFS_POP;
                end
            end
            ST_DFS_POP:
            begin
                cmd        = CMD_DFS_RESUME;
                state_next = ST_DFS_EXPAND;
            end
            ST_BFS_SEEK:
            begin
                if (status.left_zero)
                begin
                    cmd        = CMD_FINISH;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd        = CMD_BFS_START;
                    state_next = ST_BFS_EXPAND;
                end
            end
            ST_BFS_EXPAND:
            begin
                if (!status.nb_zero)
                begin
                    cmd        = CMD_BFS_EXPAND;
                    state_next = ST_BFS_ENQ;
                end
                else if (!status.queue_empty)
                begin
                    cmd        = CMD_BFS_DEQ_REQ;
                    state_next = ST_BFS_DEQ;
                end
                else
                begin
                    state_next = ST_BFS_SEEK;
                end
            end
            ST_BFS_ENQ:
            begin
                if (!status.pend_zero)
                begin
                    cmd        = CMD_BFS_ENQ;
                    state_next = ST_BFS_ENQ;
                end
                else if (!status.queue_empty)
                begin
                    cmd        = CMD_BFS_DEQ_REQ;
                    state_next = ST_BFS_DEQ;
                end
                else
                begin
                    state_next = ST_BFS_SEEK;
                end
            end
            ST_BFS_DEQ:
            begin
                cmd        = CMD_BFS_DEQ;
                state_next = ST_BFS_EXPAND;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== src/gdt_dpath.sv =====
// ----------------------------------------------------------------------------
// gdt_dpath: traversal datapath
// Config registers, adjacency memory, visited set, stack/queue memory,
// lowest-bit encoder and the one-deep result hold that sets the last flag.
// ----------------------------------------------------------------------------
module gdt_dpath
    import gdt_pkg::*;
#(
    parameter int NV = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  in_word_t         item,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output status_t          status,
    output logic             result_valid,
    output out_word_t        result
);

    localparam int VIW  = $clog2(NV);
    localparam int CNTW = $clog2(NV + 1);

    // configuration
    logic [CFG_W-1:0] vcount_reg;
    logic [CFG_W-1:0] deleted_reg;
    logic [CFG_W-1:0] eff_count;

    // adjacency memory; rows never written read as zero
    logic [NV-1:0]  adj_mem [NV];
    logic [NV-1:0]  row_valid_reg;
    logic [NV-1:0]  adj_rdata_reg;
    logic           adj_rvalid_reg;
    logic           adj_re;
    logic           adj_we;
    logic [VIW-1:0] adj_raddr;
    logic [VIW-1:0] adj_waddr;
    logic [NV-1:0]  adj_wdata;
    logic [NV-1:0]  adj_row;

    // stack / queue memory
    logic [VIW-1:0] pend_mem [NV];
    logic [VIW-1:0] pend_rdata_reg;
    logic           pend_re;
    logic           pend_we;
    logic [VIW-1:0] pend_raddr;
    logic [VIW-1:0] pend_waddr;

    logic [CNTW-1:0] top_reg;
    logic [CNTW-1:0] top_m2;
    logic [CNTW-1:0] front_reg;
    logic [CNTW-1:0] tail_reg;

    logic [VIW-1:0] a_reg;
    logic [VIW-1:0] b_reg;
    logic [NV-1:0]  act_reg;
    logic [NV-1:0]  act_next;
    logic [NV-1:0]  visited_reg;
    logic [NV-1:0]  nb_reg;
    logic [NV-1:0]  left_vec;
    logic [NV-1:0]  nb_vec;

    // lowest set bit
    logic [NV-1:0]  enc_src;
    logic [NV-1:0]  enc_onehot;
    logic [VIW-1:0] enc_idx;

    // result hold
    logic           emit;
    logic [VIW-1:0] emit_vertex;
    logic           hold_valid_reg;
    logic [VIW-1:0] hold_vertex_reg;
    logic           res_valid_reg;
    out_word_t      res_reg;

    assign eff_count = (vcount_reg > CFG_W'(NV)) ? CFG_W'(NV) : vcount_reg;

    always_comb
    begin
        for (int i = 0; i < NV; i++)
        begin
            act_next[i] = (CFG_W'(i) < eff_count) && (CFG_W'(i) != deleted_reg);
        end
    end

    assign adj_row  = adj_rvalid_reg ? adj_rdata_reg : '0;
    assign left_vec = act_reg & ~visited_reg;
    assign nb_vec   = adj_row & act_reg & ~visited_reg;
    assign top_m2   = top_reg - CNTW'(2);

    always_comb
    begin
        case (cmd)
            CMD_DFS_PUSH,
            CMD_BFS_EXPAND: enc_src = nb_vec;
            CMD_BFS_ENQ:    enc_src = nb_reg;
            default:        enc_src = left_vec;
        endcase
    end

    assign enc_onehot = enc_src & (~enc_src + NV'(1));

    always_comb
    begin
        enc_idx = '0;
        for (int i = 0; i < NV; i++)
        begin
            if (enc_onehot[i])
            begin
                enc_idx = enc_idx | VIW'(i);
            end
        end
    end

    always_comb
    begin
        status.edge_ok     = (CFG_W'(item.vertex_a) < eff_count)
                          && (CFG_W'(item.vertex_b) < eff_count);
        status.left_zero   = (left_vec == '0);
        status.nb_zero     = (nb_vec == '0);
        status.pend_zero   = (nb_reg == '0);
        status.top_one     = (top_reg == CNTW'(1));
        status.queue_empty = (front_reg == tail_reg);
    end

    // memory port steering
    always_comb
    begin
        adj_re     = 1'b0;
        adj_we     = 1'b0;
        adj_raddr  = enc_idx;
        adj_waddr  = a_reg;
        adj_wdata  = adj_row | (NV'(1) << b_reg);
        pend_re    = 1'b0;
        pend_we    = 1'b0;
        pend_raddr = front_reg[VIW-1:0];
        pend_waddr = tail_reg[VIW-1:0];
        case (cmd)
            CMD_ACCEPT:
            begin
                adj_re    = 1'b1;
                adj_raddr = item.vertex_a[VIW-1:0];
            end
            CMD_EDGE_A:
            begin
                adj_we    = 1'b1;
                adj_re    = 1'b1;
                adj_raddr = b_reg;
            end
            CMD_EDGE_B:
            begin
                adj_we    = 1'b1;
                adj_waddr = b_reg;
                adj_wdata = adj_row | (NV'(1) << a_reg);
            end
            CMD_DFS_START:
            begin
                adj_re     = 1'b1;
                pend_we    = 1'b1;
                pend_waddr = '0;
            end
            CMD_DFS_PUSH:
            begin
                adj_re     = 1'b1;
                pend_we    = 1'b1;
                pend_waddr = top_reg[VIW-1:0];
            end
            CMD_DFS_POP:
            begin
                pend_re    = 1'b1;
                pend_raddr = top_m2[VIW-1:0];
            end
            CMD_DFS_RESUME,
            CMD_BFS_DEQ:
            begin
                adj_re    = 1'b1;
                adj_raddr = pend_rdata_reg;
            end
            CMD_BFS_START:
            begin
                adj_re = 1'b1;
            end
            CMD_BFS_EXPAND,
            CMD_BFS_ENQ:
            begin
                pend_we = 1'b1;
            end
            CMD_BFS_DEQ_REQ:
            begin
                pend_re = 1'b1;
            end
            default:
            begin
                adj_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        if (adj_re)
        begin
            adj_rdata_reg <= adj_mem[adj_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pend_mem[pend_waddr] <= enc_idx;
        end
        if (pend_re)
        begin
            pend_rdata_reg <= pend_mem[pend_raddr];
        end
    end

    always_comb
    begin
        emit        = 1'b0;
        emit_vertex = enc_idx;
        case (cmd)
            CMD_DFS_START,
            CMD_DFS_PUSH,
            CMD_BFS_START: emit = 1'b1;
            CMD_BFS_DEQ:
            begin
                emit        = 1'b1;
                emit_vertex = pend_rdata_reg;
            end
            default:       emit = 1'b0;
        endcase
    end

    // payload registers without reset
    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_ACCEPT:
            begin
                a_reg   <= item.vertex_a[VIW-1:0];
                b_reg   <= item.vertex_b[VIW-1:0];
                act_reg <= act_next;
            end
            CMD_BFS_EXPAND: nb_reg <= nb_vec & ~enc_onehot;
            CMD_BFS_ENQ:    nb_reg <= nb_reg & ~enc_onehot;
            default:        nb_reg <= nb_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg      <= VERTEX_COUNT_RST;
            deleted_reg     <= DELETED_NONE;
            row_valid_reg   <= '0;
            adj_rvalid_reg  <= 1'b0;
            visited_reg     <= '0;
            top_reg         <= '0;
            front_reg       <= '0;
            tail_reg        <= '0;
            hold_valid_reg  <= 1'b0;
            hold_vertex_reg <= '0;
            res_valid_reg   <= 1'b0;
            res_reg         <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_VERTEX_COUNT:   vcount_reg  <= cfg_data;
                    CFG_DELETED_VERTEX: deleted_reg <= cfg_data;
                    default:            vcount_reg  <= vcount_reg;
                endcase
            end

            if (adj_we)
            begin
                row_valid_reg[adj_waddr] <= 1'b1;
            end
            if (adj_re)
            begin
                adj_rvalid_reg <= row_valid_reg[adj_raddr];
            end

            case (cmd)
                CMD_ACCEPT:
                begin
                    visited_reg <= '0;
                    top_reg     <= '0;
                    front_reg   <= '0;
                    tail_reg    <= '0;
                end
                CMD_DFS_START:
                begin
                    visited_reg <= visited_reg | enc_onehot;
                    top_reg     <= CNTW'(1);
                end
                CMD_DFS_PUSH:
                begin
                    visited_reg <= visited_reg | enc_onehot;
                    top_reg     <= top_reg + CNTW'(1);
                end
                CMD_DFS_POP:     top_reg     <= top_reg - CNTW'(1);
                CMD_BFS_START:   visited_reg <= visited_reg | enc_onehot;
                CMD_BFS_EXPAND:
                begin
                    visited_reg <= visited_reg | nb_vec;
                    tail_reg    <= tail_reg + CNTW'(1);
                end
                CMD_BFS_ENQ:     tail_reg    <= tail_reg + CNTW'(1);
                CMD_BFS_DEQ_REQ: front_reg   <= front_reg + CNTW'(1);
                default:         top_reg     <= top_reg;
            endcase

            // hold one visit back so the final word can carry last
            res_valid_reg <= 1'b0;
            if (cmd == CMD_ACCEPT)
            begin
                hold_valid_reg <= 1'b0;
            end
            else if (emit)
            begin
                if (hold_valid_reg)
                begin
                    res_valid_reg <= 1'b1;
                    res_reg       <= out_word_t'{vertex: VERTEX_W'(hold_vertex_reg),
                                                 empty_res: 1'b0, last: 1'b0};
                end
                hold_valid_reg  <= 1'b1;
                hold_vertex_reg <= emit_vertex;
            end
            else if (cmd == CMD_FINISH)
            begin
                res_valid_reg  <= 1'b1;
                hold_valid_reg <= 1'b0;
                if (hold_valid_reg)
                begin
                    res_reg <= out_word_t'{vertex: VERTEX_W'(hold_vertex_reg),
                                           empty_res: 1'b0, last: 1'b1};
                end
                else
                begin
                    res_reg <= out_word_t'{vertex: '0, empty_res: 1'b1, last: 1'b1};
                end
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== src/graph_dfs_bfs_traversal.sv =====
// ----------------------------------------------------------------------------
// graph_dfs_bfs_traversal: DFS / BFS engine over an adjacency bit matrix
// Stores an undirected graph and streams vertices in traversal order.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word is taken when start is high and busy is low.
//   Add-edge sets both directions of the edge, holding busy through the
//   read-modify-write of two rows; an edge with an endpoint at or above
//   the effective vertex count, and the unused opcode, leave busy low.
//   Run-DFS / run-BFS stream one result word per visited vertex, neighbors
//   in ascending order, restarting at the lowest unvisited vertex. The
//   deleted vertex is skipped. A run with no vertex gives one word with
//   empty_res and last set.
//   DFS visits a vertex on each tree start or push, backtracks with a pop
//   and a resume read, and seeks a new root when a tree's stack empties;
//   BFS enqueues each vertex reached over an edge and visits it on dequeue
//   (a request, then a read); every run closes with a finish command.
//   Runs are paced by the single adjacency read port and stack/queue port.
//   Results trail by one visit (last is known only at the next visit or the
//   run end); the final word strobes in the cycle busy falls, no stall.
//   Config channel: valid/ready, ready only while idle; index 0 vertex count,
//   index 1 deleted vertex. Reset clears the graph and restores 64 / 64.
// ----------------------------------------------------------------------------
module graph_dfs_bfs_traversal
    import gdt_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  in_word_t         item,
    output logic             busy,
    output logic             result_valid,
    output out_word_t        result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    gdt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (item.opcode),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    gdt_dpath #(
        .NV (MAX_VERTICES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

    // config only lands between commands
    assign cfg_ready = ~busy;

    // an empty run is always a single, final word
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.empty_res) |-> result.last)
        else $error("empty result without last");

    // the word after a run's final word is never a result
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |=> !result_valid)
        else $error("result right after last");

    // an idle cycle with no command produces nothing next
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !result_valid)
        else $error("result out of an idle cycle");

endmodule

// ===== dv/graph_dfs_bfs_traversal_test.sv =====
// ----------------------------------------------------------------------------
// graph_dfs_bfs_traversal_test: self-checking bench for the traversal engine
// Drives add-edge and run words through the command port, predicts every
// visit word of each DFS or BFS run from a local graph copy, and checks the
// result stream in order. The register port is exercised between phases.
// ----------------------------------------------------------------------------
module graph_dfs_bfs_traversal_test;
    import gdt_pkg::*;

    localparam int NV          = 64;
    localparam int PHASES      = 10;   // random phases, one setting each
    localparam int PHASE_WORDS = 22;   // least counted words per random phase
    localparam int SETTLE_MAX  = 20000;
    localparam int TAIL_CYCLES = 8;    // pause after the last visit word
    localparam int MAX_PRINT   = 40;

    // ------------------------------------------------------------------
    // DUT ports; every input known from time zero
    // ------------------------------------------------------------------
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    in_word_t         item      = '0;
    logic             busy;
    logic             result_valid;
    out_word_t        result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_index = CFG_VERTEX_COUNT;
    logic [CFG_W-1:0] cfg_data  = '0;

    graph_dfs_bfs_traversal i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Local copy of the engine state and its register settings
    // ------------------------------------------------------------------
    logic [NV-1:0]    graph_rows [NV];
    logic [NV-1:0]    visit_marks;
    logic [CFG_W-1:0] model_vcount  = VERTEX_COUNT_RST;
    logic [CFG_W-1:0] model_deleted = DELETED_NONE;

    in_word_t  cmd_queue[$];        // words waiting for the driver
    out_word_t expected_visits[$];  // visit words predicted, not yet seen

    int words_issued  = 0;  // driver side: words put on the port
    int words_taken   = 0;  // monitor side: words accepted by the engine
    int mismatches    = 0;
    int words_checked = 0;
    int dfs_runs      = 0;
    int bfs_runs      = 0;
    int empty_runs    = 0;
    int edge_words    = 0;
    int edges_stored  = 0;
    int unused_words  = 0;
    int cfg_writes    = 0;

    // sender burst shaping
    int burst_left = 1;
    int gap_left   = 0;

    task automatic report_mismatch(string msg);
        if (mismatches < MAX_PRINT)
            $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int first_set(logic [NV-1:0] x);
        for (int i = 0; i < NV; i++)
            if (x[i])
                return i;
        return NV;
    endfunction

    // ------------------------------------------------------------------
    // Predictor: applies one accepted word to the graph copy and queues
    // the visit words that a run of it produces.
    // ------------------------------------------------------------------
    task automatic model_command(in_word_t w);
        int          cnt;
        int          s;
        int          t;
        int          n;
        logic [NV-1:0] act;
        logic [NV-1:0] left;
        logic [NV-1:0] nb;
        logic [VERTEX_W-1:0] pend [NV];
        logic [6:0]  top;
        logic [6:0]  front;
        out_word_t   order[$];
        out_word_t   one;

        // count above the array size saturates
        cnt = (model_vcount > NV) ? NV : int'(model_vcount);

        if (w.opcode == OP_ADD_EDGE) begin
            edge_words++;
            // out-of-range endpoints leave the matrix alone
            if (w.vertex_a < cnt && w.vertex_b < cnt) begin
                graph_rows[w.vertex_a][w.vertex_b] = 1'b1;
                graph_rows[w.vertex_b][w.vertex_a] = 1'b1;
                edges_stored++;
            end
            return;
        end
        if (w.opcode != OP_RUN_DFS && w.opcode != OP_RUN_BFS) begin
            unused_words++;
            return;
        end

        act = (cnt >= NV) ? '1 : ((64'd1 << cnt) - 64'd1);
        if (model_deleted < cnt)
            act[model_deleted] = 1'b0;
        visit_marks = '0;
        top         = '0;
        front       = '0;
        one         = '0;

        left = act & ~visit_marks;
        while (left != '0) begin
            s = first_set(left);
            visit_marks[s] = 1'b1;
            if (w.opcode == OP_RUN_DFS) begin
                one.vertex = s[VERTEX_W-1:0];
                order.push_back(one);
                pend[0] = s[VERTEX_W-1:0];
                top     = 7'd1;
                while (top > 0) begin
                    t  = int'(pend[top - 7'd1]);
                    nb = graph_rows[t] & act & ~visit_marks;
                    if (nb == '0) begin
                        top = top - 7'd1;   // backtrack
                    end
                    else begin
                        n = first_set(nb);
                        visit_marks[n] = 1'b1;
                        one.vertex = n[VERTEX_W-1:0];
                        order.push_back(one);
                        if (top < NV) begin
                            pend[top[5:0]] = n[VERTEX_W-1:0];
                            top = top + 7'd1;
                        end
                    end
                end
            end
            else begin
                pend[top[5:0]] = s[VERTEX_W-1:0];
                top = top + 7'd1;
                while (front < top) begin
                    t     = int'(pend[front[5:0]]);
                    front = front + 7'd1;
                    one.vertex = t[VERTEX_W-1:0];
                    order.push_back(one);
                    nb = graph_rows[t] & act & ~visit_marks;
                    while (nb != '0) begin
                        n = first_set(nb);
                        nb[n] = 1'b0;
                        visit_marks[n] = 1'b1;
                        if (top < NV) begin
                            pend[top[5:0]] = n[VERTEX_W-1:0];
                            top = top + 7'd1;
                        end
                    end
                end
            end
            left = act & ~visit_marks;
        end

        if (w.opcode == OP_RUN_DFS)
            dfs_runs++;
        else
            bfs_runs++;

        if (order.size() == 0) begin
            // nothing active: single marker word
            one           = '0;
            one.empty_res = 1'b1;
            one.last      = 1'b1;
            order.push_back(one);
            empty_runs++;
        end
        else begin
            one      = order.pop_back();
            one.last = 1'b1;
            order.push_back(one);
        end
        foreach (order[i])
            expected_visits.push_back(order[i]);
    endtask

    // ------------------------------------------------------------------
    // Driver: one word at a time, in bursts with random gaps. A word on
    // the port is held until the monitor has seen it taken; a follow-on
    // word replaces it in the same assignment, so start does not dip between them.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end
        else if (words_issued != words_taken) begin
            // current word still waiting for a free engine
        end
        else if (gap_left > 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (cmd_queue.size() > 0) begin
            item         <= cmd_queue.pop_front();
            start        <= 1'b1;
            words_issued <= words_issued + 1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 12);
                // about a quarter of the bursts run back to back
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            else begin
                burst_left <= burst_left - 1;
            end
        end
        else begin
            start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each strobed visit word against the oldest
    // prediction, then feeds an accepted command word to the predictor.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        out_word_t want;
        if (rst_n) begin
            if (result_valid) begin
                if (expected_visits.size() == 0) begin
                    report_mismatch($sformatf("unexpected word vertex=%0d empty=%0b last=%0b",
                                              result.vertex, result.empty_res, result.last));
                end
                else begin
                    want = expected_visits.pop_front();
                    if (result.vertex !== want.vertex)
                        report_mismatch($sformatf("vertex got %0d exp %0d",
                                                  result.vertex, want.vertex));
                    if (result.empty_res !== want.empty_res)
                        report_mismatch($sformatf("empty_res got %0b exp %0b",
                                                  result.empty_res, want.empty_res));
                    if (result.last !== want.last)
                        report_mismatch($sformatf("last got %0b exp %0b (vertex %0d)",
                                                  result.last, want.last, want.vertex));
                    words_checked++;
                end
            end
            if (start && !busy) begin
                model_command(item);
                words_taken++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_word(logic [1:0] op, int a, int b);
        in_word_t w;
        w.opcode   = op;
        w.vertex_a = a[VERTEX_W-1:0];
        w.vertex_b = b[VERTEX_W-1:0];
        cmd_queue.push_back(w);
    endtask

    // Wait until the driver is empty, every word is taken and every visit
    // word has arrived; add-edge words give no result, so the wait also runs
    // until busy is low. The driver counters are looked at on the rising
    // edge, where they are stable.
    task automatic settle();
        int guard;
        guard = 0;
        while (cmd_queue.size() != 0 || words_issued != words_taken)
            @(posedge clk);
        while ((expected_visits.size() != 0 || busy) && guard < SETTLE_MAX) begin
            @(negedge clk);
            guard++;
        end
        if (expected_visits.size() != 0) begin
            report_mismatch($sformatf("%0d visit words never arrived",
                                      expected_visits.size()));
            expected_visits.delete();
        end
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_VERTEX_COUNT)
            model_vcount = val;
        else
            model_deleted = val;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int vc;
        int eff;
        int dv;
        int counted;
        int k;
        logic [1:0] run_op;

        for (int i = 0; i < NV; i++)
            graph_rows[i] = '0;
        visit_marks = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed: reset setting 64 / none, empty graph first
        queue_word(OP_RUN_DFS, 0, 0);
        queue_word(OP_RUN_BFS, 0, 0);
        queue_word(OP_UNUSED, 63, 63);       // unused opcode, dropped
        queue_word(OP_ADD_EDGE, 0, 63);
        queue_word(OP_ADD_EDGE, 0, 0);       // self loop
        queue_word(OP_ADD_EDGE, 63, 0);      // repeat of the first edge
        queue_word(OP_ADD_EDGE, 63, 1);
        queue_word(OP_RUN_DFS, 0, 0);
        queue_word(OP_RUN_BFS, 0, 0);
        settle();

        // zero count: edges dropped, every run empty
        write_reg(CFG_VERTEX_COUNT, 7'd0);
        queue_word(OP_ADD_EDGE, 0, 0);
        queue_word(OP_RUN_DFS, 0, 0);
        queue_word(OP_RUN_BFS, 0, 0);
        settle();

        // single vertex, deleted -> empty; then deletion out of range
        write_reg(CFG_VERTEX_COUNT, 7'd1);
        write_reg(CFG_DELETED_VERTEX, 7'd0);
        queue_word(OP_RUN_DFS, 0, 0);
        settle();
        write_reg(CFG_DELETED_VERTEX, 7'd127);
        queue_word(OP_RUN_BFS, 0, 0);
        settle();

        // four vertices, one deleted; vertex 0 keeps a stored neighbor 63
        write_reg(CFG_VERTEX_COUNT, 7'd4);
        write_reg(CFG_DELETED_VERTEX, 7'd2);
        queue_word(OP_ADD_EDGE, 2, 5);       // endpoint out of range
        queue_word(OP_ADD_EDGE, 1, 2);
        queue_word(OP_ADD_EDGE, 3, 2);
        queue_word(OP_ADD_EDGE, 1, 3);
        queue_word(OP_RUN_DFS, 0, 0);
        queue_word(OP_RUN_BFS, 0, 0);
        settle();
        write_reg(CFG_DELETED_VERTEX, 7'd4); // equal to the count: no effect
        queue_word(OP_RUN_DFS, 0, 0);
        settle();

        // count above 64 saturates; top vertex deleted
        write_reg(CFG_VERTEX_COUNT, 7'd127);
        write_reg(CFG_DELETED_VERTEX, 7'd63);
        queue_word(OP_RUN_DFS, 0, 0);
        queue_word(OP_RUN_BFS, 0, 0);
        settle();

        // --- random phases, mostly small graphs
        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: vc = $urandom_range(2, 10);
                6:                vc = $urandom_range(11, 40);
                7:                vc = 64;
                8:                vc = $urandom_range(65, 127);
                default:          vc = $urandom_range(1, 3);
            endcase
            eff = (vc > NV) ? NV : vc;
            case ($urandom_range(0, 5))
                0, 1, 2: dv = $urandom_range(0, eff - 1);
                3:       dv = int'(DELETED_NONE);
                4:       dv = $urandom_range(0, 127);
                default: dv = eff;
            endcase
            write_reg(CFG_VERTEX_COUNT, vc[CFG_W-1:0]);
            write_reg(CFG_DELETED_VERTEX, dv[CFG_W-1:0]);

            counted = 0;
            while (counted < PHASE_WORDS) begin
                run_op = $urandom_range(0, 1) ? OP_RUN_DFS : OP_RUN_BFS;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: begin
                        // a few in-range edges, then a run over them
                        k = $urandom_range(1, 4);
                        repeat (k)
                            queue_word(OP_ADD_EDGE, $urandom_range(0, eff - 1),
                                       $urandom_range(0, eff - 1));
                        queue_word(run_op, $urandom_range(0, 63), $urandom_range(0, 63));
                        counted += k + 1;
                    end
                    7: begin
                        // edge over the full field range, often dropped
                        queue_word(OP_ADD_EDGE, $urandom_range(0, 63), $urandom_range(0, 63));
                        counted++;
                    end
                    8: begin
                        // run with no fresh edges
                        queue_word(run_op, $urandom_range(0, 63), $urandom_range(0, 63));
                        counted++;
                    end
                    default: begin
                        queue_word(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63));
                    end
                endcase
            end
            // sender holds off here until the whole phase has drained
            settle();
        end

        $display("Ran %0d DFS and %0d BFS traversals (%0d empty), %0d visit words checked",
                 dfs_runs, bfs_runs, empty_runs, words_checked);
        $display("Sent %0d edge words (%0d stored), %0d unused-opcode words, %0d reg writes",
                 edge_words, edges_stored, unused_words, cfg_writes);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // run-away guard: far beyond the slowest legal run of this stimulus
    initial begin
        #1000000;
        $display("TIMEOUT: run did not complete");
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/gdt_pkg.sv
src/gdt_ctrl.sv
src/gdt_dpath.sv
src/graph_dfs_bfs_traversal.sv
dv/graph_dfs_bfs_traversal_test.sv
